// File: hw/rtl/bter_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bter_pkg
// Shared types, constants and the microcode table of the block Toeplitz
// row expander.
// ----------------------------------------------------------------------------
package bter_pkg;

  localparam int MAX_BLOCKS     = 4;
  localparam int MAX_TAPS       = 8;
  localparam int MAX_BLOCK_SIZE = 1024;
  localparam int VALUE_BITS     = 32;

  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int TAP_W      = $clog2(MAX_TAPS);
  localparam int ADDR_W     = BLK_W + TAP_W;
  localparam int TBL_DEPTH  = MAX_BLOCKS * MAX_TAPS;
  localparam int CNT_W      = 4;
  localparam int BS_W       = 11;
  localparam int NB_W       = 3;
  localparam int OFF_W      = 10;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_TAP_REGS = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_LAST  = 3'd5;

  typedef enum logic [1:0] {
    ST_ENTRY = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIVCHK,
    S_BLK,
    S_LEFT,
    S_RIGHT,
    S_NEXTK,
    S_FIN
  } step_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START_ROW,
    C_R_LT_BS,
    C_L_LAST,
    C_NT_ZERO,
    C_I_ZERO,
    C_RIGHT_DONE,
    C_K_LAST
  } cond_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUB,
    OP_OOR,
    OP_INIT_RS,
    OP_SET_I,
    OP_LEFT,
    OP_RIGHT,
    OP_NEXTK,
    OP_FIN
  } op_e;

  typedef struct packed {
    cond_e cond;
    step_e tgt_t;
    op_e   op_t;
    step_e tgt_f;
    op_e   op_f;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic idle;
  } seq_ctl_t;

  typedef struct packed {
    logic r_lt_bs;
    logic l_last;
    logic nt_zero;
    logic i_zero;
    logic right_done;
    logic k_last;
  } dp_flags_t;

  typedef struct packed {
    logic [BS_W-1:0]                      bs;
    logic [BLK_W-1:0]                     nbm1;
    logic [MAX_BLOCKS-1:0][CNT_W-1:0]     taps;
  } cfg_t;

  // control store: condition, then (target, op) when true and when false
  function automatic ucode_t ucode_rom(input step_e s);
    ucode_t w;
    case (s)
      S_IDLE:   w = '{C_START_ROW,  S_DIV,   OP_LOAD,    S_IDLE,   OP_NONE};
      S_DIV:    w = '{C_R_LT_BS,    S_BLK,   OP_INIT_RS, S_DIVCHK, OP_NONE};
      S_DIVCHK: w = '{C_L_LAST,     S_IDLE,  OP_OOR,     S_DIV,    OP_SUB};
      S_BLK:    w = '{C_NT_ZERO,    S_NEXTK, OP_NONE,    S_LEFT,   OP_SET_I};
      S_LEFT:   w = '{C_I_ZERO,     S_RIGHT, OP_NONE,    S_LEFT,   OP_LEFT};
      S_RIGHT:  w = '{C_RIGHT_DONE, S_NEXTK, OP_NONE,    S_RIGHT,  OP_RIGHT};
      S_NEXTK:  w = '{C_K_LAST,     S_FIN,   OP_NONE,    S_BLK,    OP_NEXTK};
      S_FIN:    w = '{C_ALWAYS,     S_IDLE,  OP_FIN,     S_IDLE,   OP_FIN};
      default:  w = '{C_ALWAYS,     S_IDLE,  OP_NONE,    S_IDLE,   OP_NONE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/bter_tap_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bter_tap_store
// Register file of generator taps: column offset and value word per entry,
// addressed as block * MAX_TAPS + tap.
// ----------------------------------------------------------------------------
module bter_tap_store import bter_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [BLK_W-1:0]      wr_blk_i,
  input  logic [TAP_W-1:0]      wr_tap_i,
  input  logic [OFF_W-1:0]      wr_off_i,
  input  logic [VALUE_BITS-1:0] wr_val_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output logic [OFF_W-1:0]      rd_off_o,
  output logic [VALUE_BITS-1:0] rd_val_o
);

  logic [OFF_W-1:0]      off_q [TBL_DEPTH];
  logic [VALUE_BITS-1:0] val_q [TBL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      off_q[{wr_blk_i, wr_tap_i}] <= wr_off_i;
      val_q[{wr_blk_i, wr_tap_i}] <= wr_val_i;
    end
  end

  assign rd_off_o = off_q[rd_addr_i];
  assign rd_val_o = val_q[rd_addr_i];

endmodule

// File: hw/rtl/bter_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bter_useq
// Microcode sequencer: step counter, control store lookup and conditional
// branch on datapath flags.
// ----------------------------------------------------------------------------
module bter_useq import bter_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_row_i,
  input  dp_flags_t flags_i,
  output seq_ctl_t  ctl_o
);

  step_e  upc_q, upc_d;
  ucode_t cw;
  logic   cond_v;

  assign cw = ucode_rom(upc_q);

  always_comb begin
    case (cw.cond)
      C_ALWAYS:     cond_v = 1'b1;
      C_START_ROW:  cond_v = start_row_i;
      C_R_LT_BS:    cond_v = flags_i.r_lt_bs;
      C_L_LAST:     cond_v = flags_i.l_last;
      C_NT_ZERO:    cond_v = flags_i.nt_zero;
      C_I_ZERO:     cond_v = flags_i.i_zero;
      C_RIGHT_DONE: cond_v = flags_i.right_done;
      C_K_LAST:     cond_v = flags_i.k_last;
      default:      cond_v = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    upc_d = cond_v ? cw.tgt_t : cw.tgt_f;
  end

  // control outputs
  always_comb begin
    ctl_o.op   = cond_v ? cw.op_t : cw.op_f;
    ctl_o.idle = (upc_q == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: hw/rtl/bter_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bter_datapath
// Row split, block and tap indexes, column arithmetic, one-entry hold stage
// that marks the final result, and the result register.
// ----------------------------------------------------------------------------
module bter_datapath import bter_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  seq_ctl_t              ctl_i,
  input  logic [ROW_W-1:0]      row_index_i,
  output logic [ADDR_W-1:0]     rd_addr_o,
  input  logic [OFF_W-1:0]      rd_off_i,
  input  logic [VALUE_BITS-1:0] rd_val_i,
  output dp_flags_t             flags_o,
  output logic                  out_vld_o,
  output logic [1:0]            status_o,
  output logic [COL_W-1:0]      col_o,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  last_o
);

  logic [ROW_W-1:0]      r_q, r_d;
  logic [BLK_W-1:0]      l_q, l_d;
  logic [BLK_W-1:0]      k_q, k_d;
  logic [COL_W-1:0]      rs_q, rs_d;      // r + k * block size
  logic [CNT_W-1:0]      i_q, i_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [COL_W-1:0]      pend_col_q, pend_col_d;
  logic [VALUE_BITS-1:0] pend_val_q, pend_val_d;
  logic                  out_vld_q, out_vld_d;
  status_e               out_st_q, out_st_d;
  logic [COL_W-1:0]      out_col_q, out_col_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic                  out_last_q, out_last_d;

  logic [BLK_W-1:0]      blk;
  logic [CNT_W-1:0]      nt;
  logic [ROW_W:0]        sum_r;
  logic                  left_hit;
  logic                  new_vld;
  logic [COL_W-1:0]      new_col;

  assign blk = (k_q >= l_q) ? (k_q - l_q) : (l_q - k_q);
  assign nt  = cfg_i.taps[blk];

  assign rd_addr_o = {blk, i_q[TAP_W-1:0]};

  assign sum_r    = {{(ROW_W + 1 - OFF_W){1'b0}}, rd_off_i} + {1'b0, r_q};
  assign left_hit = ({{(ROW_W - OFF_W){1'b0}}, rd_off_i} <= r_q);

  always_comb begin
    flags_o.r_lt_bs    = (r_q < {{(ROW_W - BS_W){1'b0}}, cfg_i.bs});
    flags_o.l_last     = (l_q == cfg_i.nbm1);
    flags_o.nt_zero    = (nt == '0);
    flags_o.i_zero     = (i_q == '0);
    flags_o.right_done = (i_q == nt) ||
                         (sum_r >= {{(ROW_W + 1 - BS_W){1'b0}}, cfg_i.bs});
    flags_o.k_last     = (k_q == cfg_i.nbm1);
  end

  always_comb begin
    new_vld = ((ctl_i.op == OP_LEFT) && left_hit) || (ctl_i.op == OP_RIGHT);
    if (ctl_i.op == OP_LEFT) begin
      new_col = rs_q - {{(COL_W - OFF_W){1'b0}}, rd_off_i};
    end else begin
      new_col = rs_q + {{(COL_W - OFF_W){1'b0}}, rd_off_i};
    end
  end

  always_comb begin
    r_d        = r_q;
    l_d        = l_q;
    k_d        = k_q;
    rs_d       = rs_q;
    i_d        = i_q;
    pend_vld_d = pend_vld_q;
    pend_col_d = pend_col_q;
    pend_val_d = pend_val_q;
    out_vld_d  = 1'b0;
    out_st_d   = out_st_q;
    out_col_d  = out_col_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    case (ctl_i.op)
      OP_LOAD: begin
        r_d        = row_index_i;
        l_d        = '0;
        k_d        = '0;
        pend_vld_d = 1'b0;
      end
      OP_SUB: begin
        r_d = r_q - {{(ROW_W - BS_W){1'b0}}, cfg_i.bs};
        l_d = l_q + 1'b1;
      end
      OP_OOR: begin
        out_vld_d  = 1'b1;
        out_st_d   = ST_RANGE;
        out_col_d  = '0;
        out_val_d  = '0;
        out_last_d = 1'b1;
      end
      OP_INIT_RS: rs_d = r_q;
      OP_SET_I:   i_d = nt - 1'b1;
      OP_LEFT:    i_d = i_q - 1'b1;
      OP_RIGHT:   i_d = i_q + 1'b1;
      OP_NEXTK: begin
        k_d  = k_q + 1'b1;
        rs_d = rs_q + {{(COL_W - BS_W){1'b0}}, cfg_i.bs};
      end
      OP_FIN: begin
        out_vld_d  = 1'b1;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
        if (pend_vld_q) begin
          out_st_d  = ST_ENTRY;
          out_col_d = pend_col_q;
          out_val_d = pend_val_q;
        end else begin
          out_st_d  = ST_EMPTY;
          out_col_d = '0;
          out_val_d = '0;
        end
      end
      default: ;
    endcase

    // a held entry goes out once the next one is found; the newest one stays
    // back so the final result can carry the last flag
    if (new_vld) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_st_d   = ST_ENTRY;
        out_col_d  = pend_col_q;
        out_val_d  = pend_val_q;
        out_last_d = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_col_d = new_col;
      pend_val_d = rd_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    l_q        <= l_d;
    k_q        <= k_d;
    rs_q       <= rs_d;
    i_q        <= i_d;
    pend_col_q <= pend_col_d;
    pend_val_q <= pend_val_d;
    out_st_q   <= out_st_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_vld_o = out_vld_q;
  assign status_o  = out_st_q;
  assign col_o     = out_col_q;
  assign val_o     = out_val_q;
  assign last_o    = out_last_q;

`ifndef ASSERT_OFF
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_st_q != ST_ENTRY)) |-> out_last_q)
    else $error("status result without last flag");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.idle |-> !pend_vld_q)
    else $error("entry held while sequencer idle");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |=> !out_vld_q)
    else $error("result right after final result");
`endif

endmodule

// File: hw/rtl/block_toeplitz_row_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_toeplitz_row_expander
// Expands one row of a symmetric block Toeplitz sparse matrix into its
// nonzero entries from per-block generator taps.
//
//   channel   signals                                        direction
//   command   start_i, busy_o (out), func_i, block_sel_i,     in
//             tap_sel_i, tap_offset_i, tap_value_i, row_index_i
//   result    result_valid_o, status_o, entry_column_o,       out
//             entry_value_o, last_entry_o
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i                in
//
// A tap load is written into tap storage while the sequencer stays idle.
// A row request runs a microcoded program: it splits the row by repeated
// subtraction of the block size, then per block column walks the taps to
// the left and then to the right, skipping a block without taps, then runs a
// finishing step. Each entry is held until the next one is found and
// shows in the next cycle; the final result is registered by the finishing step.
// The step counter and the single tap read port set the pace, one tap a cycle.
// Results are strobes of one cycle; the receiver cannot stall them.
// Reset clears the sequencer, the configuration registers and the valid
// flags; tap storage holds nothing defined until written.
// ----------------------------------------------------------------------------
module block_toeplitz_row_expander import bter_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  func_i,
  input  logic [BLK_W-1:0]      block_sel_i,
  input  logic [TAP_W-1:0]      tap_sel_i,
  input  logic [OFF_W-1:0]      tap_offset_i,
  input  logic [VALUE_BITS-1:0] tap_value_i,
  input  logic [ROW_W-1:0]      row_index_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [COL_W-1:0]      entry_column_o,
  output logic [VALUE_BITS-1:0] entry_value_o,
  output logic                  last_entry_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [BS_W-1:0]                  bs_q;
  logic [NB_W-1:0]                  nb_q;
  logic [MAX_BLOCKS-1:0][CNT_W-1:0] taps_q;
  logic [CFG_IDX_W-1:0]             tap_reg_sel;

  cfg_t                  cfg;
  logic [NB_W-1:0]       nb_eff;
  seq_ctl_t              ctl;
  dp_flags_t             flags;
  logic                  take;
  logic                  start_row;
  logic                  load_we;
  logic [ADDR_W-1:0]     rd_addr;
  logic [OFF_W-1:0]      rd_off;
  logic [VALUE_BITS-1:0] rd_val;

  assign tap_reg_sel = cfg_idx_i - REG_TAPS_FIRST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= BS_W'(1);
      nb_q   <= NB_W'(1);
      taps_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_BLOCK_SIZE) begin
        bs_q <= cfg_wdata_i[BS_W-1:0];
      end else if (cfg_idx_i == REG_NUM_BLOCKS) begin
        nb_q <= cfg_wdata_i[NB_W-1:0];
      end else if (cfg_idx_i inside {[REG_TAPS_FIRST:REG_TAPS_LAST]}) begin
        taps_q[tap_reg_sel[BLK_W-1:0]] <= cfg_wdata_i[CNT_W-1:0];
      end
    end
  end

  // clamp register values to the supported ranges
  always_comb begin
    if (bs_q == '0) begin
      cfg.bs = BS_W'(1);
    end else if (bs_q > BS_W'(MAX_BLOCK_SIZE)) begin
      cfg.bs = BS_W'(MAX_BLOCK_SIZE);
    end else begin
      cfg.bs = bs_q;
    end

    if (nb_q == '0) begin
      nb_eff = NB_W'(1);
    end else if (nb_q > NB_W'(MAX_BLOCKS)) begin
      nb_eff = NB_W'(MAX_BLOCKS);
    end else begin
      nb_eff = nb_q;
    end
    cfg.nbm1 = BLK_W'(nb_eff - 1'b1);

    for (int b = 0; b < MAX_BLOCKS; b++) begin
      cfg.taps[b] = (taps_q[b] > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : taps_q[b];
    end
  end

  assign busy_o    = !ctl.idle;
  assign take      = start_i && ctl.idle;
  assign start_row = take && func_i;
  assign load_we   = take && !func_i;

  bter_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_row_i (start_row),
    .flags_i     (flags),
    .ctl_o       (ctl)
  );

  bter_tap_store u_taps (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .wr_blk_i  (block_sel_i),
    .wr_tap_i  (tap_sel_i),
    .wr_off_i  (tap_offset_i),
    .wr_val_i  (tap_value_i),
    .rd_addr_i (rd_addr),
    .rd_off_o  (rd_off),
    .rd_val_o  (rd_val)
  );

  bter_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctl_i       (ctl),
    .row_index_i (row_index_i),
    .rd_addr_o   (rd_addr),
    .rd_off_i    (rd_off),
    .rd_val_i    (rd_val),
    .flags_o     (flags),
    .out_vld_o   (result_valid_o),
    .status_o    (status_o),
    .col_o       (entry_column_o),
    .val_o       (entry_value_o),
    .last_o      (last_entry_o)
  );

endmodule
